// ----- sv/hsfl_pkg.sv -----
// ----------------------------------------------------------------------------
// hsfl_pkg
// Shared types, codes and defaults of the handle slab free list unit.
// ----------------------------------------------------------------------------
package hsfl_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int ENTRY_WIDTH_DEFAULT = 32;

    localparam int CMD_W    = 3;
    localparam int HANDLE_W = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 7;

    localparam logic [LIMIT_W-1:0] SLOT_LIMIT_RESET = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_GET      = 3'd1,
        CMD_RENUMBER = 3'd2,
        CMD_REMOVE   = 3'd3,
        CMD_CLEAR    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

endpackage

// ----- sv/hsfl_ram.sv -----
// ----------------------------------------------------------------------------
// hsfl_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module hsfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/handle_slab_free_list_unit.sv -----
// ----------------------------------------------------------------------------
// handle_slab_free_list_unit
// Fixed-depth handle table with a linked free list: insert, get, renumber,
// remove and clear, one result item per command item.
// ----------------------------------------------------------------------------
// One command item is accepted every cycle while the result side keeps up.
// The RAM reads and the execute register load at the accepting edge, and the
// result register loads as the item commits. Throughput is one item per clock
// without stalls, set by the single pass through the execute stage. A result
// held by m_tready low stalls the execute stage and then the input, with at
// most two items inside. RAM reads launch as an item is accepted, and a write
// from the item ahead at the same edge is forwarded. The tables are never
// cleared after reset, so the block is ready right away; slots are initialized
// as the used length grows over them.
module handle_slab_free_list_unit #(
    parameter int DEPTH       = hsfl_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = hsfl_pkg::ENTRY_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: slot_limit
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    // command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // handle[5:0], target_handle[11:6], entry_data[43:12]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // handle_out[5:0], entry_out[37:6]
    output logic [1:0]  m_tuser    // status[1:0]
);

    import hsfl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > LIMIT_W) ? LW : LIMIT_W;
    localparam int EW = ENTRY_WIDTH;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // ---------------- control state ----------------
    logic [LIMIT_W-1:0] slot_limit_reg;
    logic [CW-1:0]      used_reg, used_next;
    logic [CW-1:0]      head_reg, head_next;
    logic               v1_reg;
    logic               out_valid_reg;

    // ---------------- execute stage payload ----------------
    cmd_t                cmd1_reg;
    logic [HANDLE_W-1:0] h1_reg;
    logic [HANDLE_W-1:0] t1_reg;
    logic [DATA_W-1:0]   d1_reg;

    // forwarding of the write at the read edge
    logic          occ_h_hit_reg, occ_t_hit_reg, occ_bd_reg;
    logic          ent_h_hit_reg, ent_t_hit_reg;
    logic [EW-1:0] ent_bd_reg;
    logic          lnk_hit_reg;
    logic [CW-1:0] lnk_bd_reg;

    // ---------------- result register ----------------
    status_t             status_reg;
    logic [HANDLE_W-1:0] hout_reg;
    logic [DATA_W-1:0]   eout_reg;

    // ---------------- handshake ----------------
    logic commit;
    logic accept;

    assign commit    = v1_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !v1_reg || commit;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // ---------------- RAM ports ----------------
    logic [HANDLE_W-1:0] h_in, t_in;
    logic [CW-1:0]       h_in_ext, t_in_ext;
    logic [AW-1:0]       h_in_addr, t_in_addr;

    assign h_in      = s_tdata[5:0];
    assign t_in      = s_tdata[11:6];
    assign h_in_ext  = CW'(h_in);
    assign t_in_ext  = CW'(t_in);
    assign h_in_addr = h_in_ext[AW-1:0];
    assign t_in_addr = t_in_ext[AW-1:0];

    logic          occ_we_x, occ_we;
    logic [AW-1:0] occ_wa;
    logic          occ_wd;
    logic          ent_we_x, ent_we;
    logic [AW-1:0] ent_wa;
    logic [EW-1:0] ent_wd;
    logic          lnk_we_x, lnk_we;
    logic [AW-1:0] lnk_wa;
    logic [CW-1:0] lnk_wd;
    logic [CW-1:0] lnk_ra_full;
    logic [AW-1:0] lnk_ra;

    assign occ_we = commit && occ_we_x;
    assign ent_we = commit && ent_we_x;
    assign lnk_we = commit && lnk_we_x;

    // the next item reads the link at the head this item leaves behind
    assign lnk_ra_full = commit ? head_next : head_reg;
    assign lnk_ra      = lnk_ra_full[AW-1:0];

    logic          occ_h_rd, occ_t_rd;
    logic [EW-1:0] ent_h_rd, ent_t_rd;
    logic [CW-1:0] lnk_rd;

    hsfl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_h (
        .aclk(aclk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
        .re(accept), .raddr(h_in_addr), .rdata(occ_h_rd)
    );

    hsfl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ_t (
        .aclk(aclk), .we(occ_we), .waddr(occ_wa), .wdata(occ_wd),
        .re(accept), .raddr(t_in_addr), .rdata(occ_t_rd)
    );

    hsfl_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ent_h (
        .aclk(aclk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
        .re(accept), .raddr(h_in_addr), .rdata(ent_h_rd)
    );

    hsfl_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ent_t (
        .aclk(aclk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd),
        .re(accept), .raddr(t_in_addr), .rdata(ent_t_rd)
    );

    hsfl_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_lnk (
        .aclk(aclk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd),
        .re(accept), .raddr(lnk_ra), .rdata(lnk_rd)
    );

    // ---------------- execute stage ----------------
    logic          occ_h, occ_t;
    logic [EW-1:0] ent_h, ent_t;
    logic [CW-1:0] lnk;

    assign occ_h = occ_h_hit_reg ? occ_bd_reg : occ_h_rd;
    assign occ_t = occ_t_hit_reg ? occ_bd_reg : occ_t_rd;
    assign ent_h = ent_h_hit_reg ? ent_bd_reg : ent_h_rd;
    assign ent_t = ent_t_hit_reg ? ent_bd_reg : ent_t_rd;
    assign lnk   = lnk_hit_reg   ? lnk_bd_reg : lnk_rd;

    logic [CW-1:0] h_ext, t_ext;
    logic [AW-1:0] h_addr, t_addr;
    logic [CW-1:0] sl_ext, limit;
    logic          valid_h, valid_t;
    logic          grow;
    logic [CW-1:0] slot;
    logic [63:0]   data_wide;
    logic [63:0]   eout_wide;

    status_t       status_x;
    logic [HANDLE_W-1:0] hout_x;
    logic [EW-1:0] eout_x;

    assign h_ext     = CW'(h1_reg);
    assign t_ext     = CW'(t1_reg);
    assign h_addr    = h_ext[AW-1:0];
    assign t_addr    = t_ext[AW-1:0];
    assign sl_ext    = CW'(slot_limit_reg);
    assign limit     = (sl_ext < DEPTH_C) ? sl_ext : DEPTH_C;
    assign valid_h   = (h_ext < used_reg) && (h_ext < DEPTH_C) && occ_h;
    assign valid_t   = (t_ext < used_reg) && (t_ext < DEPTH_C) && occ_t;
    assign grow      = (head_reg == used_reg);
    assign slot      = head_reg;
    assign data_wide = 64'(d1_reg);
    assign eout_wide = 64'(eout_x);

    always_comb begin
        status_x  = ST_OK;
        hout_x    = '0;
        eout_x    = '0;
        used_next = used_reg;
        head_next = head_reg;
        occ_we_x  = 1'b0;
        occ_wa    = h_addr;
        occ_wd    = 1'b0;
        ent_we_x  = 1'b0;
        ent_wa    = t_addr;
        ent_wd    = ent_h;
        lnk_we_x  = 1'b0;
        lnk_wa    = h_addr;
        lnk_wd    = head_reg;
        if (v1_reg) begin
            case (cmd1_reg)
                CMD_INSERT: begin
                    if (grow && (used_reg >= limit)) begin
                        status_x = ST_FULL;
                    end else if (head_reg >= DEPTH_C) begin
                        status_x = ST_FULL;
                    end else begin
                        // a fresh slot links straight past itself
                        if (grow) begin
                            used_next = used_reg + CW'(1);
                            head_next = used_reg + CW'(1);
                        end else begin
                            head_next = lnk;
                        end
                        occ_we_x = 1'b1;
                        occ_wa   = slot[AW-1:0];
                        occ_wd   = 1'b1;
                        ent_we_x = 1'b1;
                        ent_wa   = slot[AW-1:0];
                        ent_wd   = data_wide[EW-1:0];
                        hout_x   = slot[HANDLE_W-1:0];
                    end
                end
                CMD_GET: begin
                    if (!valid_h) begin
                        status_x = ST_BAD;
                    end else begin
                        eout_x = ent_h;
                    end
                end
                CMD_RENUMBER: begin
                    if (!(valid_h && valid_t)) begin
                        status_x = ST_BAD;
                    end else begin
                        // the first handle is freed, so only the target slot's entry is written
                        eout_x    = ent_t;
                        ent_we_x  = 1'b1;
                        occ_we_x  = 1'b1;
                        lnk_we_x  = 1'b1;
                        head_next = h_ext;
                    end
                end
                CMD_REMOVE: begin
                    if (!valid_h) begin
                        status_x = ST_BAD;
                    end else begin
                        eout_x    = ent_h;
                        occ_we_x  = 1'b1;
                        lnk_we_x  = 1'b1;
                        head_next = h_ext;
                    end
                end
                CMD_CLEAR: begin
                    used_next = '0;
                    head_next = '0;
                end
                default: begin
                    status_x = ST_BAD;
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_limit_reg <= SLOT_LIMIT_RESET;
            used_reg       <= '0;
            head_reg       <= '0;
            v1_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                slot_limit_reg <= cfg_data;
            end
            if (commit) begin
                used_reg <= used_next;
                head_reg <= head_next;
            end
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (commit) begin
                v1_reg <= 1'b0;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd1_reg      <= cmd_t'(s_tuser);
            h1_reg        <= h_in;
            t1_reg        <= t_in;
            d1_reg        <= s_tdata[43:12];
            occ_h_hit_reg <= occ_we && (occ_wa == h_in_addr);
            occ_t_hit_reg <= occ_we && (occ_wa == t_in_addr);
            occ_bd_reg    <= occ_wd;
            ent_h_hit_reg <= ent_we && (ent_wa == h_in_addr);
            ent_t_hit_reg <= ent_we && (ent_wa == t_in_addr);
            ent_bd_reg    <= ent_wd;
            lnk_hit_reg   <= lnk_we && (lnk_wa == lnk_ra);
            lnk_bd_reg    <= lnk_wd;
        end
        if (commit) begin
            status_reg <= status_x;
            hout_reg   <= hout_x;
            eout_reg   <= eout_wide[DATA_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, eout_reg, hout_reg};
    assign m_tuser  = status_reg;

`ifndef NO_ASSERTIONS
    // the used length never runs past the table depth
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= DEPTH_C)
        else $error("used length beyond depth");

    // the free head is a freed slot or the end marker at the used length
    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= used_reg)
        else $error("free head beyond used length");

    // a blocked result register stalls the execute stage and the input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && out_valid_reg && !m_tready) |-> (!s_tready && !commit))
        else $error("execute stage moved while result blocked");

    // no state change unless an item leaves the execute stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> ($stable(used_reg) && $stable(head_reg)))
        else $error("table state changed without a committed item");
`endif

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the handle slab free list unit: a directed run over
// the corner cases, then random command streams under several slot limits and
// idle/stall patterns, checked item by item against a table model.
// ----------------------------------------------------------------------------
module testbench;
    import hsfl_pkg::*;

    localparam int TABLE_DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    // codes past CMD_CLEAR are undefined; the block must answer them with ST_BAD
    localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] target;
        logic [DATA_W-1:0]   data;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle_out;
        logic [DATA_W-1:0]   entry_out;
    } table_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // handle[5:0], target_handle[11:6], entry_data[43:12]
    logic [2:0]  s_tuser   = '0;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // handle_out[5:0], entry_out[37:6]
    logic [1:0]  m_tuser;          // status[1:0]

    handle_slab_free_list_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // table model state
    bit              slot_busy  [TABLE_DEPTH];
    bit [6:0]        slot_next  [TABLE_DEPTH];
    bit [DATA_W-1:0] slot_entry [TABLE_DEPTH];
    bit [6:0]        head_slot  = '0;
    bit [6:0]        used_slots = '0;
    bit [6:0]        slot_limit = SLOT_LIMIT_RESET;

    cmd_item_t     pending_q[$];
    table_result_t result_q[$];
    cmd_item_t     drv_item;
    bit            item_taken   = 1'b0;
    int            issued_count = 0;
    int            result_count = 0;
    int            fail_count   = 0;
    int            cycle_count  = 0;
    int            idle_pct     = 0;
    int            stall_pct    = 0;
    bit            pressure_on  = 1'b0;
    int            hold_cnt     = 0;

    function automatic bit handle_live(logic [HANDLE_W-1:0] h);
        return ({1'b0, h} < used_slots) && slot_busy[h];
    endfunction

    task automatic release_slot(logic [HANDLE_W-1:0] h);
        slot_busy[h] = 1'b0;
        slot_next[h] = head_slot;
        head_slot    = {1'b0, h};
    endtask

    task automatic apply_command(input cmd_item_t it, output table_result_t res);
        bit [6:0]            cap;
        bit [HANDLE_W-1:0]   slot;
        bit [DATA_W-1:0]     tmp;
        res        = '0;
        res.status = ST_OK;
        cap = (slot_limit < 7'(TABLE_DEPTH)) ? slot_limit : 7'(TABLE_DEPTH);
        case (it.cmd)
            CMD_INSERT: begin
                if (head_slot == used_slots && used_slots >= cap) begin
                    res.status = ST_FULL;
                end else begin
                    // free list empty: grow by one fresh slot
                    if (head_slot == used_slots) begin
                        slot_busy[used_slots[5:0]] = 1'b0;
                        slot_next[used_slots[5:0]] = used_slots + 7'd1;
                        used_slots = used_slots + 7'd1;
                    end
                    if (head_slot >= 7'(TABLE_DEPTH)) begin
                        res.status = ST_FULL;
                    end else begin
                        slot             = head_slot[5:0];
                        head_slot        = slot_next[slot];
                        slot_busy[slot]  = 1'b1;
                        slot_entry[slot] = it.data;
                        res.handle_out   = slot;
                    end
                end
            end
            CMD_GET: begin
                if (!handle_live(it.handle)) res.status = ST_BAD;
                else res.entry_out = slot_entry[it.handle];
            end
            CMD_RENUMBER: begin
                if (!handle_live(it.handle) || !handle_live(it.target)) begin
                    res.status = ST_BAD;
                end else begin
                    tmp                   = slot_entry[it.handle];
                    slot_entry[it.handle] = slot_entry[it.target];
                    slot_entry[it.target] = tmp;
                    res.entry_out         = slot_entry[it.handle];
                    release_slot(it.handle);
                end
            end
            CMD_REMOVE: begin
                if (!handle_live(it.handle)) begin
                    res.status = ST_BAD;
                end else begin
                    res.entry_out = slot_entry[it.handle];
                    release_slot(it.handle);
                end
            end
            CMD_CLEAR: begin
                used_slots = '0;
                head_slot  = '0;
            end
            default: res.status = ST_BAD;
        endcase
    endtask

    function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] c, logic [HANDLE_W-1:0] h,
                                           logic [HANDLE_W-1:0] t, logic [DATA_W-1:0] d);
        cmd_item_t it;
        it.cmd    = c;
        it.handle = h;
        it.target = t;
        it.data   = d;
        return it;
    endfunction

    // handles mostly fall in the live range of the current limit so that
    // get/remove/renumber hit occupied slots; the rest cover the full field
    function automatic cmd_item_t random_command(int span);
        cmd_item_t it;
        int        pick;
        int        dsel;
        pick = $urandom_range(0, 99);
        dsel = $urandom_range(0, 19);
        it.handle = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, span - 1));
        it.target = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, span - 1));
        if (dsel == 0) it.data = '0;
        else if (dsel == 1) it.data = '1;
        else it.data = $urandom;
        if (pick < 38) it.cmd = CMD_INSERT;
        else if (pick < 58) it.cmd = CMD_GET;
        else if (pick < 73) it.cmd = CMD_RENUMBER;
        else if (pick < 96) it.cmd = CMD_REMOVE;
        else if (pick < 98) it.cmd = CMD_CLEAR;
        else it.cmd = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
        return it;
    endfunction

    task automatic issue(input cmd_item_t it);
        pending_q.push_back(it);
        issued_count++;
    endtask

    task automatic wait_drained;
        while (result_count < issued_count) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input logic [6:0] limit, input int idle, input int stall,
                              input int count, input bit hold);
        int span;
        int k;
        write_limit(limit);
        span = (limit == 0) ? 1 : ((limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(limit));
        idle_pct  = idle;
        stall_pct = stall;
        if (hold) pressure_on = 1'b1;
        for (k = 0; k < count; k++) issue(random_command(span));
        wait_drained();
    endtask

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || item_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                drv_item = pending_q.pop_front();
                s_tdata  <= {4'b0, drv_item.data, drv_item.target, drv_item.handle};
                s_tuser  <= drv_item.cmd;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off when pressure is requested
    always @(negedge aclk) begin
        if (pressure_on && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt++;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : monitor_blk
        table_result_t want;
        table_result_t got;
        item_taken = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.status     = m_tuser;
                got.handle_out = m_tdata[5:0];
                got.entry_out  = m_tdata[37:6];
                result_count++;
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result item: status %0d handle_out %0d entry_out %h",
                                 got.status, got.handle_out, got.entry_out);
                end else begin
                    want = result_q.pop_front();
                    if (got.status != want.status || got.handle_out != want.handle_out ||
                        got.entry_out != want.entry_out) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"mismatch (exp/got): status %0d/%0d handle_out %0d/%0d ",
                                      "entry_out %h/%h"}, want.status, got.status,
                                     want.handle_out, got.handle_out,
                                     want.entry_out, got.entry_out);
                    end
                end
            end
            if (cfg_valid && cfg_ready) slot_limit = cfg_data;
            if (item_taken) begin
                apply_command(drv_item, want);
                result_q.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, reset limit
        issue(make_cmd(CMD_GET,      6'd0,  6'd0,  32'h0));
        issue(make_cmd(CMD_REMOVE,   6'd63, 6'd0,  32'h0));
        issue(make_cmd(CMD_RENUMBER, 6'd0,  6'd63, 32'h0));
        issue(make_cmd(CMD_INSERT,   6'd0,  6'd0,  32'h0000_0000));
        issue(make_cmd(CMD_INSERT,   6'd63, 6'd63, 32'hFFFF_FFFF));
        issue(make_cmd(CMD_INSERT,   6'd21, 6'd42, 32'h5A5A_5A5A));
        issue(make_cmd(CMD_GET,      6'd0,  6'd0,  32'h0));
        issue(make_cmd(CMD_GET,      6'd1,  6'd0,  32'h0));
        issue(make_cmd(CMD_GET,      6'd63, 6'd0,  32'h0));
        issue(make_cmd(CMD_RENUMBER, 6'd1,  6'd0,  32'h0));
        issue(make_cmd(CMD_GET,      6'd1,  6'd0,  32'h0));   // now a free slot
        issue(make_cmd(CMD_RENUMBER, 6'd2,  6'd1,  32'h0));   // second handle bad
        issue(make_cmd(CMD_RENUMBER, 6'd1,  6'd2,  32'h0));   // first handle bad
        issue(make_cmd(CMD_RENUMBER, 6'd0,  6'd0,  32'h0));   // onto itself
        issue(make_cmd(CMD_INSERT,   6'd0,  6'd0,  32'h1234_5678));
        issue(make_cmd(CMD_INSERT,   6'd0,  6'd0,  32'h8000_0001));
        issue(make_cmd(CMD_INSERT,   6'd0,  6'd0,  32'hA5A5_A5A5));
        issue(make_cmd(CMD_REMOVE,   6'd2,  6'd0,  32'h0));
        issue(make_cmd(CMD_REMOVE,   6'd2,  6'd0,  32'h0));
        issue(make_cmd(CMD_UNDEF_LO, 6'd63, 6'd63, 32'hFFFF_FFFF));
        issue(make_cmd(3'd6,         6'd1,  6'd2,  32'hDEAD_BEEF));
        issue(make_cmd(CMD_UNDEF_HI, 6'd0,  6'd0,  32'h0));
        issue(make_cmd(CMD_CLEAR,    6'd0,  6'd0,  32'h0));
        issue(make_cmd(CMD_GET,      6'd0,  6'd0,  32'h0));
        issue(make_cmd(CMD_INSERT,   6'd0,  6'd0,  32'hCAFE_F00D));
        issue(make_cmd(CMD_GET,      6'd0,  6'd0,  32'h0));
        wait_drained();

        // limit of one: slot 0 is in use, so the table is full
        write_limit(7'd1);
        issue(make_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h1111_1111));
        issue(make_cmd(CMD_REMOVE, 6'd0, 6'd0, 32'h0));
        issue(make_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h2222_2222));
        issue(make_cmd(CMD_GET,    6'd0, 6'd0, 32'h0));
        wait_drained();

        // limit of zero: only a freed slot can be reused
        write_limit(7'd0);
        issue(make_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h3333_3333));
        issue(make_cmd(CMD_REMOVE, 6'd0, 6'd0, 32'h0));
        issue(make_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h4444_4444));
        issue(make_cmd(CMD_CLEAR,  6'd0, 6'd0, 32'h0));
        issue(make_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h5555_5555));
        issue(make_cmd(CMD_GET,    6'd0, 6'd0, 32'h0));
        wait_drained();

        run_random(7'd64,  0,  0,  300, 1'b0);
        run_random(7'd127, 79, 0,  250, 1'b0);   // saturates at table depth
        run_random(7'd8,   0,  79, 250, 1'b0);
        run_random(7'd100, 8,  8,  250, 1'b0);
        run_random(7'd64,  0,  0,  200, 1'b1);
        run_random(7'd2,   8,  8,  150, 1'b0);
        run_random(7'($urandom_range(1, 64)), 79, 0, 150, 1'b0);

        repeat (10) @(negedge aclk);
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hsfl_pkg.sv
sv/hsfl_ram.sv
sv/handle_slab_free_list_unit.sv
sim/testbench.sv
